[hdl/assert_macros.svh]
// Assertion macros for the RTL files.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/pvlm_pkg.sv]
// Package for the point voxel label mapper: constants and register indexes.
// No dependencies; imported by the top level.
package pvlm_pkg;

    localparam int STORE_DEPTH = 262144;
    localparam int STORE_AW    = 18;
    localparam int LABEL_W     = 8;
    localparam int DATA_W      = 32;
    localparam int MAG_W       = 33;
    localparam int PROD_W      = 64;
    localparam int Q_W         = 41;
    localparam int MIN_W       = 24;
    localparam int MAX_W       = 23;
    localparam int CFG_IDX_W   = 3;
    localparam int AXES        = 3;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING_Z = 3'd5;

    localparam logic [DATA_W-1:0] INV_SPACING_RESET = 32'h0001_0000;

    localparam logic signed [MIN_W-1:0] IDX_MIN = 24'sh80_0000;
    localparam logic [MAX_W-1:0]        IDX_MAX = 23'h7F_FFFF;

    localparam logic                    MODE_LOAD = 1'b0;

endpackage

[hdl/pvlm_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; used by the top level for the voxel label store.
module pvlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/point_voxel_label_mapper_top.sv]
// Point voxel label mapper top level: config registers, sequencer, label store.
// Depends on pvlm_pkg, pvlm_ram and assert_macros.svh.
// A load transaction (mode 0) writes one label into the 256K x 8 store in the
// accept cycle, so loads stream at one per cycle while no map is in flight. A
// map transaction (mode 1) runs a state sequence: each axis passes through
// offset add, 32x32 multiply and high-part correction on the one shared
// multiplier, then S_CLASS classifies bounds, S_ADDR issues the store read and
// S_DONE writes the result register. No new transaction is taken until a map
// has written its result; a held result stalls only S_DONE. The store has no
// reset; entries must be loaded before they are mapped.
`include "assert_macros.svh"

module point_voxel_label_mapper_top
    import pvlm_pkg::*;
#(
    parameter int DIM_X = 64,
    parameter int DIM_Y = 64,
    parameter int DIM_Z = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [DATA_W-1:0]           cfg_data,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        mode,
    input  logic [STORE_AW-1:0]         voxel_address,
    input  logic [LABEL_W-1:0]          voxel_label,
    input  logic signed [DATA_W-1:0]    coord_x,
    input  logic signed [DATA_W-1:0]    coord_y,
    input  logic signed [DATA_W-1:0]    coord_z,
    input  logic signed [DATA_W-1:0]    old_region,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [DATA_W-1:0]    new_region,
    output logic                        relabelled,
    output logic                        below_bounds,
    output logic                        above_bounds,
    output logic [DATA_W-1:0]           relabel_total,
    output logic signed [MIN_W-1:0]     lowest_i,
    output logic signed [MIN_W-1:0]     lowest_j,
    output logic signed [MIN_W-1:0]     lowest_k,
    output logic [MAX_W-1:0]            highest_i,
    output logic [MAX_W-1:0]            highest_j,
    output logic [MAX_W-1:0]            highest_k
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_MUL,
        S_ACC,
        S_CLASS,
        S_ADDR,
        S_DONE
    } state_t;

    localparam logic [Q_W-1:0]      DIM_X_M1 = Q_W'(DIM_X - 1);
    localparam logic [Q_W-1:0]      DIM_Y_M1 = Q_W'(DIM_Y - 1);
    localparam logic [Q_W-1:0]      DIM_Z_M1 = Q_W'(DIM_Z - 1);
    localparam logic [STORE_AW-1:0] DIM_X_A  = STORE_AW'(DIM_X);
    localparam logic [STORE_AW-1:0] DIM_Y_A  = STORE_AW'(DIM_Y);
    localparam logic [Q_W-1:0]      Q_SAT_MIN = Q_W'(2**(MIN_W-1));
    localparam logic [Q_W-1:0]      Q_SAT_MAX = Q_W'(2**MAX_W - 1);

    state_t state_reg;
    logic [1:0] axis_reg;

    logic [DATA_W-1:0] offset_reg [AXES];
    logic [DATA_W-1:0] inv_reg    [AXES];

    logic [DATA_W-1:0]   coord_reg [AXES];
    logic [DATA_W-1:0]   region_reg;
    logic [MAG_W-1:0]    mag_reg;
    logic                neg_cur_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                hi_reg;
    logic [Q_W-1:0]      q_reg   [AXES];
    logic                neg_reg [AXES];
    logic [STORE_AW-1:0] row_reg;
    logic                below_reg;
    logic                above_reg;

    logic [DATA_W-1:0]           relabel_cnt_reg;
    logic signed [MIN_W-1:0]     min_reg [AXES];
    logic [MAX_W-1:0]            max_reg [AXES];
    logic                        out_valid_reg;
    logic signed [DATA_W-1:0]    new_region_reg;
    logic                        relabelled_reg;
    logic                        below_out_reg;
    logic                        above_out_reg;

    logic                  in_accept;
    logic                  load_we;
    logic [MAG_W-1:0]      t_sum;
    logic [MAG_W-1:0]      t_mag;
    logic [Q_W-1:0]        q_next;
    logic [AXES-1:0]       below_ax;
    logic [AXES-1:0]       above_ax;
    logic [Q_W-1:0]        dim_m1 [AXES];
    logic [STORE_AW-1:0]   rd_addr;
    logic                  rd_en;
    logic [LABEL_W-1:0]    rd_label;
    logic [LABEL_W-1:0]    label;
    logic                  hit;
    logic                  done_fire;
    logic signed [MIN_W-1:0] min_cand [AXES];
    logic [MAX_W-1:0]        max_cand [AXES];
    logic signed [MIN_W-1:0] min_next [AXES];
    logic [MAX_W-1:0]        max_next [AXES];

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign load_we   = in_accept && (mode == MODE_LOAD);
    assign done_fire = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    assign dim_m1[0] = DIM_X_M1;
    assign dim_m1[1] = DIM_Y_M1;
    assign dim_m1[2] = DIM_Z_M1;

    // offset add and magnitude for the axis in flight
    assign t_sum = {coord_reg[axis_reg][DATA_W-1], coord_reg[axis_reg]}
                 + {offset_reg[axis_reg][DATA_W-1], offset_reg[axis_reg]};
    assign t_mag = t_sum[MAG_W-1] ? (~t_sum + MAG_W'(1)) : t_sum;

    // add back the bit-32 partial product, drop 24 fraction bits
    assign q_next = {1'b0, prod_reg[PROD_W-1:24]}
                  + (hi_reg ? {1'b0, inv_reg[axis_reg], 8'b0} : '0);

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            below_ax[a] = neg_reg[a] && (q_reg[a] != '0);
            above_ax[a] = !neg_reg[a] && (q_reg[a] > dim_m1[a]);
            min_cand[a] = (q_reg[a] >= Q_SAT_MIN) ? IDX_MIN
                        : -$signed({1'b0, q_reg[a][MAX_W-1:0]});
            max_cand[a] = (q_reg[a] > Q_SAT_MAX) ? IDX_MAX : q_reg[a][MAX_W-1:0];
            min_next[a] = (below_reg && below_ax[a] && (min_cand[a] < min_reg[a]))
                        ? min_cand[a] : min_reg[a];
            max_next[a] = (above_reg && (max_cand[a] > max_reg[a]))
                        ? max_cand[a] : max_reg[a];
        end
    end

    assign rd_en    = (state_reg == S_ADDR);
    assign rd_addr  = q_reg[0][STORE_AW-1:0] + DIM_X_A * row_reg;
    assign label    = (below_reg || above_reg) ? '0 : rd_label;
    assign hit      = (label != '0);

    pvlm_ram #(
        .WIDTH (LABEL_W),
        .DEPTH (STORE_DEPTH)
    ) u_label_store (
        .clk   (clk),
        .we    (load_we),
        .waddr (voxel_address),
        .wdata (voxel_label),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_label)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                offset_reg[a] <= '0;
                inv_reg[a]    <= INV_SPACING_RESET;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OFFSET_X:      offset_reg[0] <= cfg_data;
                REG_OFFSET_Y:      offset_reg[1] <= cfg_data;
                REG_OFFSET_Z:      offset_reg[2] <= cfg_data;
                REG_INV_SPACING_X: inv_reg[0]    <= cfg_data;
                REG_INV_SPACING_Y: inv_reg[1]    <= cfg_data;
                REG_INV_SPACING_Z: inv_reg[2]    <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                coord_reg[0] <= coord_x;
                coord_reg[1] <= coord_y;
                coord_reg[2] <= coord_z;
                region_reg   <= old_region;
            end
            S_ADD:
            begin
                mag_reg     <= t_mag;
                neg_cur_reg <= t_sum[MAG_W-1];
            end
            S_MUL:
            begin
                prod_reg <= PROD_W'(mag_reg[DATA_W-1:0]) * PROD_W'(inv_reg[axis_reg]);
                hi_reg   <= mag_reg[MAG_W-1];
            end
            S_ACC:
            begin
                q_reg[axis_reg]   <= q_next;
                neg_reg[axis_reg] <= neg_cur_reg;
            end
            S_CLASS:
            begin
                below_reg <= |below_ax;
                above_reg <= !(|below_ax) && (|above_ax);
                row_reg   <= q_reg[1][STORE_AW-1:0] + DIM_Y_A * q_reg[2][STORE_AW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            axis_reg        <= '0;
            relabel_cnt_reg <= '0;
            min_reg[0]      <= '0;
            min_reg[1]      <= '0;
            min_reg[2]      <= '0;
            max_reg[0]      <= MAX_W'(DIM_X - 1);
            max_reg[1]      <= MAX_W'(DIM_Y - 1);
            max_reg[2]      <= MAX_W'(DIM_Z - 1);
            out_valid_reg   <= 1'b0;
            new_region_reg  <= '0;
            relabelled_reg  <= 1'b0;
            below_out_reg   <= 1'b0;
            above_out_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !done_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    axis_reg <= '0;
                    if (in_accept && (mode != MODE_LOAD))
                    begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD:   state_reg <= S_MUL;
                S_MUL:   state_reg <= S_ACC;
                S_ACC:
                begin
                    if (axis_reg == 2'd2)
                    begin
                        state_reg <= S_CLASS;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= S_ADD;
                    end
                end
                S_CLASS: state_reg <= S_ADDR;
                S_ADDR:  state_reg <= S_DONE;
                S_DONE:
                begin
                    if (done_fire)
                    begin
                        for (int a = 0; a < AXES; a++)
                        begin
                            min_reg[a] <= min_next[a];
                            max_reg[a] <= max_next[a];
                        end
                        if (hit && (relabel_cnt_reg != '1))
                        begin
                            relabel_cnt_reg <= relabel_cnt_reg + DATA_W'(1);
                        end
                        new_region_reg <= hit ? $signed(DATA_W'(label)) : region_reg;
                        relabelled_reg <= hit;
                        below_out_reg  <= below_reg;
                        above_out_reg  <= above_reg;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign new_region    = new_region_reg;
    assign relabelled    = relabelled_reg;
    assign below_bounds  = below_out_reg;
    assign above_bounds  = above_out_reg;
    assign relabel_total = relabel_cnt_reg;
    assign lowest_i      = min_reg[0];
    assign lowest_j      = min_reg[1];
    assign lowest_k      = min_reg[2];
    assign highest_i     = max_reg[0];
    assign highest_j     = max_reg[1];
    assign highest_k     = max_reg[2];

    `ASSERT_IMPLIES(a_bounds_exclusive, clk, rst_n, out_valid_reg,
                    !(below_out_reg && above_out_reg))
    `ASSERT_IMPLIES(a_hit_in_bounds, clk, rst_n, out_valid_reg && relabelled_reg,
                    !below_out_reg && !above_out_reg)
    `ASSERT_IMPLIES(a_hit_label_range, clk, rst_n, out_valid_reg && relabelled_reg,
                    (new_region_reg[DATA_W-1:LABEL_W] == '0) &&
                    (new_region_reg[LABEL_W-1:0] != '0))
    `ASSERT_NEXT(a_count_monotonic, clk, rst_n, 1'b1,
                 relabel_cnt_reg >= $past(relabel_cnt_reg))

endmodule

[tb/label_map_tb_pkg.sv]
`timescale 1ns / 100ps
// Transaction types, voxel index arithmetic and the region scoreboard for the label mapper.
// Depends on pvlm_pkg; imported by tb_top.
package label_map_tb_pkg;
    import pvlm_pkg::*;

    localparam int GRID_X = 64;
    localparam int GRID_Y = 64;
    localparam int GRID_Z = 64;

    localparam logic MODE_MAP = ~MODE_LOAD;

    typedef struct packed {
        logic                    mode;
        logic [STORE_AW-1:0]     voxel_address;
        logic [LABEL_W-1:0]      voxel_label;
        logic [DATA_W-1:0]       coord_x;
        logic [DATA_W-1:0]       coord_y;
        logic [DATA_W-1:0]       coord_z;
        logic [DATA_W-1:0]       old_region;
    } voxel_txn_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] new_region;
        logic                     relabelled;
        logic                     below_bounds;
        logic                     above_bounds;
        logic [DATA_W-1:0]        relabel_total;
        logic signed [MIN_W-1:0]  lowest_i;
        logic signed [MIN_W-1:0]  lowest_j;
        logic signed [MIN_W-1:0]  lowest_k;
        logic [MAX_W-1:0]         highest_i;
        logic [MAX_W-1:0]         highest_j;
        logic [MAX_W-1:0]         highest_k;
    } region_result_t;

    function automatic int grid_dim(int axis);
        case (axis)
            0: return GRID_X;
            1: return GRID_Y;
            default: return GRID_Z;
        endcase
    endfunction

    // Offset, scale by Q16.16 reciprocal, truncate toward zero.
    function automatic longint voxel_index(logic [DATA_W-1:0] coord, logic [DATA_W-1:0] off,
                                           logic [DATA_W-1:0] inv);
        logic signed [MAG_W-1:0] sum;
        logic [MAG_W-1:0]        mag;
        logic [PROD_W-1:0]       prod;
        longint                  q;
        sum  = $signed({coord[DATA_W-1], coord}) + $signed({off[DATA_W-1], off});
        mag  = sum[MAG_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
        prod = {31'd0, mag} * {32'd0, inv};
        q    = longint'({24'd0, prod[PROD_W-1:24]});
        return sum[MAG_W-1] ? -q : q;
    endfunction

    class region_scoreboard;
        logic [LABEL_W-1:0] voxel_labels [];
        logic [DATA_W-1:0]  offset [3];
        logic [DATA_W-1:0]  inv_spacing [3];
        longint             lowest [3];
        longint             highest [3];
        logic [DATA_W-1:0]  relabel_count;
        region_result_t     expected_regions [$];
        int                 errors;

        function new();
            voxel_labels = new[STORE_DEPTH];
            for (int a = 0; a < AXES; a++) begin
                offset[a]      = '0;
                inv_spacing[a] = INV_SPACING_RESET;
                lowest[a]      = 0;
                highest[a]     = grid_dim(a) - 1;
            end
            relabel_count = '0;
            errors        = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
            case (idx)
                REG_OFFSET_X:      offset[0] = val;
                REG_OFFSET_Y:      offset[1] = val;
                REG_OFFSET_Z:      offset[2] = val;
                REG_INV_SPACING_X: inv_spacing[0] = val;
                REG_INV_SPACING_Y: inv_spacing[1] = val;
                REG_INV_SPACING_Z: inv_spacing[2] = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_regions.size();
        endfunction

        // Predict the region for one accepted map, or record the label of an accepted load.
        function void note_accepted(voxel_txn_t t);
            longint             idx [3];
            logic [DATA_W-1:0]  coord [3];
            logic [LABEL_W-1:0] lab;
            logic [STORE_AW-1:0] addr;
            bit                 lo;
            bit                 hi;
            region_result_t     want;
            if (t.mode == MODE_LOAD) begin
                voxel_labels[t.voxel_address] = t.voxel_label;
                return;
            end
            coord[0] = t.coord_x;
            coord[1] = t.coord_y;
            coord[2] = t.coord_z;
            lo = 1'b0;
            hi = 1'b0;
            for (int a = 0; a < AXES; a++) begin
                idx[a] = voxel_index(coord[a], offset[a], inv_spacing[a]);
                if (idx[a] < 0) lo = 1'b1;
                if (idx[a] > grid_dim(a) - 1) hi = 1'b1;
            end
            if (lo) hi = 1'b0;
            lab = '0;
            if (lo) begin
                for (int a = 0; a < AXES; a++) begin
                    if (idx[a] < lowest[a]) lowest[a] = idx[a];
                    if (lowest[a] < longint'(IDX_MIN)) lowest[a] = longint'(IDX_MIN);
                end
            end else if (hi) begin
                for (int a = 0; a < AXES; a++) begin
                    if (idx[a] > highest[a]) highest[a] = idx[a];
                    if (highest[a] > longint'(IDX_MAX)) highest[a] = longint'(IDX_MAX);
                end
            end else begin
                addr = STORE_AW'(idx[0] + GRID_X * (idx[1] + GRID_Y * idx[2]));
                lab  = voxel_labels[addr];
            end
            if (lab != 0 && relabel_count != '1) relabel_count++;
            want.new_region    = (lab != 0) ? DATA_W'(lab) : t.old_region;
            want.relabelled    = (lab != 0);
            want.below_bounds  = lo;
            want.above_bounds  = hi;
            want.relabel_total = relabel_count;
            want.lowest_i      = MIN_W'(lowest[0]);
            want.lowest_j      = MIN_W'(lowest[1]);
            want.lowest_k      = MIN_W'(lowest[2]);
            want.highest_i     = MAX_W'(highest[0]);
            want.highest_j     = MAX_W'(highest[1]);
            want.highest_k     = MAX_W'(highest[2]);
            expected_regions.push_back(want);
        endfunction

        function void compare_field(string field, logic [DATA_W-1:0] want,
                                    logic [DATA_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t mismatch %s: expected %h actual %h", $time, field, want, got);
            end
        endfunction

        function void check_region(region_result_t got);
            region_result_t want;
            if (expected_regions.size() == 0) begin
                errors++;
                $display("%0t result with no transaction pending: expected none actual %h",
                         $time, got.new_region);
                return;
            end
            want = expected_regions.pop_front();
            compare_field("new_region", want.new_region, got.new_region);
            compare_field("relabelled", DATA_W'(want.relabelled), DATA_W'(got.relabelled));
            compare_field("below_bounds", DATA_W'(want.below_bounds),
                          DATA_W'(got.below_bounds));
            compare_field("above_bounds", DATA_W'(want.above_bounds),
                          DATA_W'(got.above_bounds));
            compare_field("relabel_total", want.relabel_total, got.relabel_total);
            compare_field("lowest_i", DATA_W'(want.lowest_i), DATA_W'(got.lowest_i));
            compare_field("lowest_j", DATA_W'(want.lowest_j), DATA_W'(got.lowest_j));
            compare_field("lowest_k", DATA_W'(want.lowest_k), DATA_W'(got.lowest_k));
            compare_field("highest_i", DATA_W'(want.highest_i), DATA_W'(got.highest_i));
            compare_field("highest_j", DATA_W'(want.highest_j), DATA_W'(got.highest_j));
            compare_field("highest_k", DATA_W'(want.highest_k), DATA_W'(got.highest_k));
        endfunction
    endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top for point_voxel_label_mapper_top: clock, reset, drivers and result checks.
// Depends on pvlm_pkg, label_map_tb_pkg and the block's RTL.
module tb_top;
    import pvlm_pkg::*;
    import label_map_tb_pkg::*;

    localparam int RUN_LIMIT     = 1000000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 230;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]        cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic                     mode;
    logic [STORE_AW-1:0]      voxel_address;
    logic [LABEL_W-1:0]       voxel_label;
    logic signed [DATA_W-1:0] coord_x;
    logic signed [DATA_W-1:0] coord_y;
    logic signed [DATA_W-1:0] coord_z;
    logic signed [DATA_W-1:0] old_region;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] new_region;
    logic                     relabelled;
    logic                     below_bounds;
    logic                     above_bounds;
    logic [DATA_W-1:0]        relabel_total;
    logic signed [MIN_W-1:0]  lowest_i;
    logic signed [MIN_W-1:0]  lowest_j;
    logic signed [MIN_W-1:0]  lowest_k;
    logic [MAX_W-1:0]         highest_i;
    logic [MAX_W-1:0]         highest_j;
    logic [MAX_W-1:0]         highest_k;

    region_scoreboard         board;
    bit                       loaded [STORE_DEPTH];
    logic [STORE_AW-1:0]      loaded_list [$];
    logic [DATA_W-1:0]        setting [6];
    logic [DATA_W-1:0]        cur_offset [3];
    logic [DATA_W-1:0]        cur_inv [3];
    int                       in_calm;
    int                       out_calm;

    point_voxel_label_mapper_top #(
        .DIM_X(GRID_X),
        .DIM_Y(GRID_Y),
        .DIM_Z(GRID_Z)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode(mode),
        .voxel_address(voxel_address),
        .voxel_label(voxel_label),
        .coord_x(coord_x),
        .coord_y(coord_y),
        .coord_z(coord_z),
        .old_region(old_region),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .new_region(new_region),
        .relabelled(relabelled),
        .below_bounds(below_bounds),
        .above_bounds(above_bounds),
        .relabel_total(relabel_total),
        .lowest_i(lowest_i),
        .lowest_j(lowest_j),
        .lowest_k(lowest_k),
        .highest_i(highest_i),
        .highest_j(highest_j),
        .highest_k(highest_k)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
        begin
            calm = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    function automatic logic [LABEL_W-1:0] random_label();
        return ($urandom_range(0, 3) == 0) ? LABEL_W'(0) : LABEL_W'($urandom);
    endfunction

    // Pick a Q23.8 coordinate that lands near the wanted index under the current setting.
    function automatic logic [DATA_W-1:0] coord_for(longint idx, int axis);
        longint mag;
        longint pos;
        if (cur_inv[axis] == 0)
            return $urandom;
        mag = ((idx < 0 ? -idx : idx) <<< 24) + longint'($urandom_range(0, 32'hFF_FFFF));
        pos = mag / longint'(cur_inv[axis]);
        if (idx < 0 || (idx == 0 && $urandom_range(0, 1) == 1))
            pos = -pos;
        return DATA_W'(pos - longint'($signed(cur_offset[axis])));
    endfunction

    function automatic longint target_index(int axis, bit in_grid);
        int dim;
        dim = grid_dim(axis);
        if (in_grid)
        begin
            case ($urandom_range(0, 3))
                0: return 0;
                1: return dim - 1;
                default: return $urandom_range(0, dim - 1);
            endcase
        end
        case ($urandom_range(0, 5))
            0: return -longint'($urandom_range(1, 3));
            1: return longint'(dim + $urandom_range(0, 2));
            2: return -longint'($urandom_range(1, 9000000));
            3: return longint'($urandom_range(dim, 9000000));
            default: return $urandom_range(0, dim - 1);
        endcase
    endfunction

    task automatic send_item(voxel_txn_t t);
        int gap;
        gap = draw_gap(in_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= t.mode;
        voxel_address <= t.voxel_address;
        voxel_label   <= t.voxel_label;
        coord_x       <= t.coord_x;
        coord_y       <= t.coord_y;
        coord_z       <= t.coord_z;
        old_region    <= t.old_region;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_accepted(t);
    endtask

    task automatic send_load(logic [STORE_AW-1:0] addr, logic [LABEL_W-1:0] lab);
        voxel_txn_t t;
        t.mode          = MODE_LOAD;
        t.voxel_address = addr;
        t.voxel_label   = lab;
        t.coord_x       = $urandom;
        t.coord_y       = $urandom;
        t.coord_z       = $urandom;
        t.old_region    = $urandom;
        if (!loaded[addr])
        begin
            loaded[addr] = 1'b1;
            loaded_list.push_back(addr);
        end
        send_item(t);
    endtask

    // Load the target voxel first if the point would read an empty entry.
    task automatic send_map(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y,
                            logic [DATA_W-1:0] z, logic [DATA_W-1:0] old);
        voxel_txn_t          t;
        longint              i;
        longint              j;
        longint              k;
        logic [STORE_AW-1:0] addr;
        i = voxel_index(x, cur_offset[0], cur_inv[0]);
        j = voxel_index(y, cur_offset[1], cur_inv[1]);
        k = voxel_index(z, cur_offset[2], cur_inv[2]);
        if (i >= 0 && i < GRID_X && j >= 0 && j < GRID_Y && k >= 0 && k < GRID_Z)
        begin
            addr = STORE_AW'(i + GRID_X * (j + GRID_Y * k));
            if (!loaded[addr])
                send_load(addr, random_label());
        end
        t.mode          = MODE_MAP;
        t.voxel_address = STORE_AW'($urandom);
        t.voxel_label   = LABEL_W'($urandom);
        t.coord_x       = x;
        t.coord_y       = y;
        t.coord_z       = z;
        t.old_region    = old;
        send_item(t);
    endtask

    task automatic random_map();
        longint              idx [3];
        logic [DATA_W-1:0]   c [3];
        logic [STORE_AW-1:0] a;
        int                  kind;
        bit                  in_grid;
        kind = $urandom_range(0, 19);
        if (kind < 2)
        begin
            for (int n = 0; n < AXES; n++)
                c[n] = $urandom;
        end
        else
        begin
            in_grid = (kind < 14);
            if (in_grid && kind < 7 && loaded_list.size() > 0)
            begin
                a = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                idx[0] = a % GRID_X;
                idx[1] = (a / GRID_X) % GRID_Y;
                idx[2] = a / (GRID_X * GRID_Y);
            end
            else
            begin
                for (int n = 0; n < AXES; n++)
                    idx[n] = target_index(n, in_grid);
            end
            for (int n = 0; n < AXES; n++)
                c[n] = coord_for(idx[n], n);
        end
        send_map(c[0], c[1], c[2], $urandom);
    endtask

    task automatic run_random(int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                if ($urandom_range(0, 1) == 0 || loaded_list.size() == 0)
                    send_load(STORE_AW'($urandom), random_label());
                else
                    send_load(loaded_list[$urandom_range(0, loaded_list.size() - 1)],
                              random_label());
            end
            else
                random_map();
        end
    endtask

    task automatic run_corners();
        send_map(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_map(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_map(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_map(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Default setting: one voxel per millimetre, index is coordinate over 256.
    task automatic run_directed();
        send_load(18'h00000, 8'hFF);
        send_load(18'h3FFFF, 8'h01);
        send_load(18'h00001, 8'h00);
        send_load(18'h2AAAA, 8'h55);
        send_load(18'h15555, 8'hAA);
        send_map(32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF);
        send_map(32'd16383, 32'd16383, 32'd16383, 32'h8000_0000);
        send_map(32'd256, 32'd0, 32'd0, 32'h8000_0000);
        send_map(32'hFFFF_FFFF, 32'hFFFF_FF01, 32'd0, 32'h1234_5678);
        send_map(32'd10880, 32'd10880, 32'd10880, 32'h5555_5555);
        send_map(32'd5376, 32'd5376, 32'd5376, 32'hAAAA_AAAA);
        send_map(32'hFFFF_FF00, 32'd0, 32'd0, 32'h0000_0001);
        send_map(32'd16384, 32'd0, 32'd0, 32'h0000_0002);
        send_map(32'd0, 32'd16384, 32'hFFFF_FF00, 32'h0000_0003);
        send_map(32'd0, 32'd0, 32'd16384, 32'h0000_0004);
        run_corners();
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        board.set_register(idx, val);
    endtask

    task automatic choose_setting(int p);
        case (p)
            0:
            begin
                setting = '{32'd128, 32'd128, 32'd128, 32'h0001_0000, 32'h0001_0000,
                            32'h0001_0000};
            end
            1:
            begin
                setting = '{32'hFFFF_FC18, 32'd5000, 32'h0000_1234, 32'h0002_0000,
                            32'h0000_8000, 32'h0001_8000};
            end
            2:
            begin
                setting = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd1};
            end
            3:
            begin
                for (int n = 0; n < AXES; n++)
                begin
                    setting[n]     = $urandom;
                    setting[n + 3] = $urandom_range(32'h4000, 32'h10_0000);
                end
            end
            4:
            begin
                setting = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF};
            end
            default:
            begin
                setting = '{32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'h0000_4000, 32'h0004_0000};
            end
        endcase
    endtask

    task automatic apply_setting();
        write_register(REG_OFFSET_X, setting[0]);
        write_register(REG_OFFSET_Y, setting[1]);
        write_register(REG_OFFSET_Z, setting[2]);
        write_register(REG_INV_SPACING_X, setting[3]);
        write_register(REG_INV_SPACING_Y, setting[4]);
        write_register(REG_INV_SPACING_Z, setting[5]);
        cfg_we <= 1'b0;
        @(posedge clk);
        for (int n = 0; n < AXES; n++)
        begin
            cur_offset[n] = setting[n];
            cur_inv[n]    = setting[n + 3];
        end
    endtask

    // Hold off until every expected result is back and the pipeline is empty.
    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_OFFSET_X;
        cfg_data      = '0;
        in_valid      = 1'b0;
        mode          = MODE_LOAD;
        voxel_address = '0;
        voxel_label   = '0;
        coord_x       = '0;
        coord_y       = '0;
        coord_z       = '0;
        old_region    = '0;
        in_calm       = 0;
        out_calm      = 0;
        for (int n = 0; n < AXES; n++)
        begin
            cur_offset[n] = '0;
            cur_inv[n]    = INV_SPACING_RESET;
        end
        board = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            choose_setting(p);
            apply_setting();
            run_corners();
            run_random(PHASE_ITEMS);
        end
        settle();
        if (board.errors == 0 && board.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin : result_side
        int             gap;
        region_result_t got;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap(out_calm);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            got.new_region    = new_region;
            got.relabelled    = relabelled;
            got.below_bounds  = below_bounds;
            got.above_bounds  = above_bounds;
            got.relabel_total = relabel_total;
            got.lowest_i      = lowest_i;
            got.lowest_j      = lowest_j;
            got.lowest_k      = lowest_k;
            got.highest_i     = highest_i;
            got.highest_j     = highest_j;
            got.highest_k     = highest_k;
            board.check_region(got);
        end
    end

    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule
